>>> sv/tone_events_to_midi_track_defines.svh
// Assertion macros for the tone-event MIDI track writer.
`ifndef TONE_EVENTS_TO_MIDI_TRACK_DEFINES_SVH
`define TONE_EVENTS_TO_MIDI_TRACK_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define TETM_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("tetm assertion failed (same cycle)");

// Next-cycle implication, disabled while reset is held.
`define TETM_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("tetm assertion failed (next cycle)");

`endif

>>> sv/tetm_pkg.sv
// ---------------------------------------------------------------------------
// tetm_pkg
// Types, codes and constant tables shared by the MIDI track writer.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tetm_pkg;

    localparam logic [1:0] MODE_START = 2'd0;
    localparam logic [1:0] MODE_TONE  = 2'd1;
    localparam logic [1:0] MODE_END   = 2'd2;

    localparam logic [7:0] REG_INSTRUMENT = 8'd0;
    localparam logic [7:0] REG_VELOCITY   = 8'd1;

    localparam logic [6:0] INSTRUMENT_RST = 7'd16;
    localparam logic [6:0] VELOCITY_RST   = 7'd64;

    localparam logic [27:0] DELTA_MAX  = 28'h0FFF_FFFF;
    localparam logic [31:0] TRACK_SKIP = 32'd22;
    localparam logic [31:0] START_LEN  = 32'd32;
    localparam logic [31:0] END_LEN    = 32'd4;

    localparam logic [7:0] NOTE_ON      = 8'h90;
    localparam logic [7:0] NOTE_OFF     = 8'h80;
    localparam logic [7:0] META_PREFIX  = 8'hFF;
    localparam logic [7:0] META_EOT     = 8'h2F;
    localparam logic [4:0] START_LAST   = 5'd31;
    localparam logic [4:0] END_LAST     = 5'd3;

    // File header, tempo event and program change; the final entry is
    // replaced by the instrument register.
    localparam logic [7:0] HDR_BYTES [0:31] = '{
        8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
        8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h64,
        8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20,
        8'h00, 8'hC0, 8'h00
    };

    typedef enum logic [1:0] {
        KIND_START,
        KIND_TONE,
        KIND_END
    } t_kind;

    typedef struct packed {
        t_kind       kind;
        logic [6:0]  note;
        logic [27:0] delta;
        logic [27:0] dur;
        logic [2:0]  dcnt;
        logic [2:0]  ucnt;
        logic [31:0] tlen;
    } t_job;

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] tlen;
    } t_byte;

    // Number of 7-bit groups in the variable-length form of a value.
    function automatic logic [2:0] vlq_len(input logic [27:0] v);
        logic [2:0] n;
        if (v[27:21] != 7'd0) begin
            n = 3'd4;
        end else if (v[20:14] != 7'd0) begin
            n = 3'd3;
        end else if (v[13:7] != 7'd0) begin
            n = 3'd2;
        end else begin
            n = 3'd1;
        end
        return n;
    endfunction

    function automatic logic [6:0] vlq_group(input logic [27:0] v, input logic [1:0] g);
        logic [6:0] r;
        case (g)
            2'd0:    r = v[6:0];
            2'd1:    r = v[13:7];
            2'd2:    r = v[20:14];
            default: r = v[27:21];
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

>>> sv/tetm_byte_sel.sv
// ---------------------------------------------------------------------------
// tetm_byte_sel
// Picks the byte at a given position of the current item's output run.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tetm_byte_sel (
    input  var tetm_pkg::t_job  i_job,
    input  wire logic [4:0]     i_idx,
    input  wire logic [6:0]     i_instrument,
    input  wire logic [6:0]     i_velocity,
    output var tetm_pkg::t_byte o_byte
);
    import tetm_pkg::*;

    always_comb begin
        logic [4:0] p;
        logic [4:0] q;
        logic [1:0] g;
        o_byte = '0;
        p = i_idx - {2'b00, i_job.dcnt};
        q = p - 5'd3 - {2'b00, i_job.ucnt};
        g = 2'd0;
        unique case (i_job.kind)
            KIND_START: begin
                o_byte.data = (i_idx == START_LAST) ? {1'b0, i_instrument} : HDR_BYTES[i_idx];
                o_byte.last = (i_idx == START_LAST);
            end
            KIND_END: begin
                case (i_idx[1:0])
                    2'd1:    o_byte.data = META_PREFIX;
                    2'd2:    o_byte.data = META_EOT;
                    default: o_byte.data = 8'h00;
                endcase
                o_byte.last = (i_idx == END_LAST);
                o_byte.tlen = o_byte.last ? i_job.tlen : 32'd0;
            end
            KIND_TONE: begin
                if (i_idx < {2'b00, i_job.dcnt}) begin
                    g = 2'(i_job.dcnt - 3'd1 - i_idx[2:0]);
                    o_byte.data = {(g != 2'd0), vlq_group(i_job.delta, g)};
                end else if (p < 5'd3) begin
                    case (p[1:0])
                        2'd0:    o_byte.data = NOTE_ON;
                        2'd1:    o_byte.data = {1'b0, i_job.note};
                        default: o_byte.data = {1'b0, i_velocity};
                    endcase
                end else if (p < 5'd3 + {2'b00, i_job.ucnt}) begin
                    g = 2'(i_job.ucnt - 3'd1 - 3'(p - 5'd3));
                    o_byte.data = {(g != 2'd0), vlq_group(i_job.dur, g)};
                end else begin
                    case (q[1:0])
                        2'd0:    o_byte.data = NOTE_OFF;
                        2'd1:    o_byte.data = {1'b0, i_job.note};
                        default: o_byte.data = {1'b0, i_velocity};
                    endcase
                    o_byte.last = (q == 5'd2);
                end
            end
            default: o_byte = '0;
        endcase
    end

endmodule

`default_nettype wire

>>> sv/tetm_out_stage.sv
// ---------------------------------------------------------------------------
// tetm_out_stage
// Output register holding one byte until the downstream side takes it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tetm_out_stage (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_load,
    input  var tetm_pkg::t_byte  i_byte,
    output wire logic            o_free,
    output wire logic            o_m_tvalid,
    input  wire logic            i_m_tready,
    output wire logic [39:0]     o_m_tdata,
    output wire logic            o_m_tlast
);
    import tetm_pkg::*;

    logic  r_valid;
    t_byte r_byte;

    assign o_free     = !r_valid || i_m_tready;
    assign o_m_tvalid = r_valid;
    assign o_m_tdata  = {r_byte.tlen, r_byte.data};
    assign o_m_tlast  = r_byte.last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_byte <= i_byte;
        end
    end

endmodule

`default_nettype wire

>>> sv/tetm_ctrl.sv
// ---------------------------------------------------------------------------
// tetm_ctrl
// Takes input items, keeps delta and byte count, and steps through the
// output run of the item held in the job register.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tetm_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_s_tvalid,
    output wire logic           o_s_tready,
    input  wire logic [39:0]    i_s_tdata,
    input  wire logic [2:0]     i_s_tuser,
    input  wire logic           i_free,
    input  wire logic           i_last,
    output wire logic           o_step,
    output var tetm_pkg::t_job  o_job,
    output wire logic [4:0]     o_idx
);
    import tetm_pkg::*;

    logic        r_busy;
    logic [4:0]  r_idx;
    t_job        r_job;
    logic [27:0] r_pending;
    logic [31:0] r_count;

    logic        n_busy;
    logic [4:0]  n_idx;
    t_job        n_job;
    logic [27:0] n_pending;
    logic [31:0] n_count;

    logic        accept;
    logic        emits;
    logic [1:0]  mode;
    logic        silent;
    logic [6:0]  note;
    logic [27:0] dur;
    logic [28:0] sum;
    logic [2:0]  dl;
    logic [2:0]  ul;

    assign mode   = i_s_tuser[1:0];
    assign silent = i_s_tuser[2];
    assign note   = i_s_tdata[6:0];
    assign dur    = i_s_tdata[34:7];

    assign o_step     = r_busy && i_free;
    assign o_s_tready = !r_busy || (o_step && i_last);
    assign accept     = i_s_tvalid && o_s_tready;
    assign o_job      = r_job;
    assign o_idx      = r_idx;

    assign sum = {1'b0, r_pending} + {1'b0, dur};
    assign dl  = vlq_len(r_pending);
    assign ul  = vlq_len(dur);

    always_comb begin
        n_pending = r_pending;
        n_count   = r_count;
        n_job     = r_job;
        emits     = 1'b0;
        if (accept) begin
            n_job.note  = note;
            n_job.delta = r_pending;
            n_job.dur   = dur;
            n_job.dcnt  = dl;
            n_job.ucnt  = ul;
            unique case (mode)
                MODE_START: begin
                    emits       = 1'b1;
                    n_job.kind  = KIND_START;
                    n_pending   = 28'd0;
                    n_count     = START_LEN;
                end
                MODE_TONE: begin
                    if (silent) begin
                        n_pending = sum[28] ? DELTA_MAX : sum[27:0];
                    end else begin
                        emits      = 1'b1;
                        n_job.kind = KIND_TONE;
                        n_pending  = 28'd0;
                        n_count    = r_count + 32'({1'b0, dl} + {1'b0, ul} + 4'd6);
                    end
                end
                MODE_END: begin
                    emits      = 1'b1;
                    n_job.kind = KIND_END;
                    n_count    = r_count + END_LEN;
                end
                default: emits = 1'b0;
            endcase
            n_job.tlen = n_count - TRACK_SKIP;
        end
    end

    always_comb begin
        n_busy = r_busy;
        n_idx  = r_idx;
        if (accept && emits) begin
            n_busy = 1'b1;
            n_idx  = 5'd0;
        end else if (o_step && i_last) begin
            n_busy = 1'b0;
        end else if (o_step) begin
            n_idx = r_idx + 5'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_idx     <= 5'd0;
            r_pending <= 28'd0;
            r_count   <= 32'd0;
        end else begin
            r_busy    <= n_busy;
            r_idx     <= n_idx;
            r_pending <= n_pending;
            r_count   <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emits) begin
            r_job <= n_job;
        end
    end

endmodule

`default_nettype wire

>>> sv/tone_events_to_midi_track.sv
// An accepted item is held in the job register; its bytes then pass to the output register.
// Throughput: one byte per cycle unless the output stalls; an item holds the input until its
// last byte loads (start 32 bytes, note 8 to 14, end 4); rests and unused codes emit none.
// The next item is taken in the cycle its predecessor's last byte enters the output register.
// Reset (synchronous, active low) clears delta and byte count, empties the output register
// and restores the instrument to 16 and the velocity to 64.
// ---------------------------------------------------------------------------
// tone_events_to_midi_track
// Writes a one-track Standard MIDI File byte stream from tone events.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tone_events_to_midi_track (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output wire logic        o_s_tready,
    input  wire logic [39:0] i_s_tdata,   // note [6:0], duration [34:7], zero [39:35]
    input  wire logic [2:0]  i_s_tuser,   // mode [1:0], is_silence [2]
    output wire logic        o_m_tvalid,
    input  wire logic        i_m_tready,
    output wire logic [39:0] o_m_tdata,   // out_byte [7:0], track_length [39:8]
    output wire logic        o_m_tlast,   // last_of_run
    input  wire logic        i_cfg_valid,
    output wire logic        o_cfg_ready,
    input  wire logic [7:0]  i_cfg_index,
    input  wire logic [6:0]  i_cfg_data
);
    import tetm_pkg::*;

    logic [6:0] r_instr;
    logic [6:0] r_velocity;
    logic       free;
    logic       step;
    t_job       job;
    t_byte      cur;
    logic [4:0] idx;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_instr    <= INSTRUMENT_RST;
            r_velocity <= VELOCITY_RST;
        end else if (i_cfg_valid) begin
            if (i_cfg_index == REG_INSTRUMENT) begin
                r_instr <= i_cfg_data;
            end
            if (i_cfg_index == REG_VELOCITY) begin
                r_velocity <= i_cfg_data;
            end
        end
    end

    tetm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_free     (free),
        .i_last     (cur.last),
        .o_step     (step),
        .o_job      (job),
        .o_idx      (idx)
    );

    tetm_byte_sel u_sel (
        .i_job        (job),
        .i_idx        (idx),
        .i_instrument (r_instr),
        .i_velocity   (r_velocity),
        .o_byte       (cur)
    );

    tetm_out_stage u_out (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_load     (step),
        .i_byte     (cur),
        .o_free     (free),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

endmodule

`default_nettype wire

>>> sv/tetm_checker.sv
// ---------------------------------------------------------------------------
// tetm_checker
// Port-level checks on the MIDI track writer, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "tone_events_to_midi_track_defines.svh"

module tetm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_s_tvalid,
    input wire logic        o_s_tready,
    input wire logic [39:0] i_s_tdata,
    input wire logic [2:0]  i_s_tuser,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [39:0] o_m_tdata,
    input wire logic        o_m_tlast,
    input wire logic        i_cfg_valid,
    input wire logic        o_cfg_ready,
    input wire logic [7:0]  i_cfg_index,
    input wire logic [6:0]  i_cfg_data
);

    // A stalled output item holds still.
    `TETM_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))

    // A track length only ever rides on the closing zero byte of end-of-track.
    `TETM_ASSERT_NOW(a_tlen_on_last, i_clk, i_rst_n, o_m_tvalid && (o_m_tdata[39:8] != 32'd0), o_m_tlast && (o_m_tdata[7:0] == 8'h00))

    // While the input is held off, a run is in progress, so a byte is on offer next cycle.
    `TETM_ASSERT_NEXT(a_busy_feeds_out, i_clk, i_rst_n, !o_s_tready, o_m_tvalid)

endmodule

bind tone_events_to_midi_track tetm_checker u_tetm_checker (.*);

`default_nettype wire

>>> bench/tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb
// Self-checking bench for the tone-event MIDI track writer. A directed table
// covers the field extremes, every mode, the VLQ length boundaries and delta
// saturation. Random start / note / rest / end sequences with some noise
// follow, under several instrument and velocity settings. Every output item
// is compared with a predictor kept inside the bench, with random stalls on
// both streams.
// ---------------------------------------------------------------------------

module tb;
    import tetm_pkg::*;

    localparam logic [1:0]  MODE_UNUSED   = 2'd3;
    localparam logic [27:0] TICKS_MAX     = 28'h0FFF_FFFF;
    localparam logic [31:0] CHUNK_OFFSET  = 32'd22;
    localparam int          RAND_ITEMS    = 430;
    localparam int          N_PHASES      = 5;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          QUIET_LIMIT   = 2000;
    localparam int          DIR_ROWS      = 25;

    // File header and tempo event, first byte in the top bits.
    localparam logic [29*8-1:0] SMF_HEAD = {
        8'h4D, 8'h54, 8'h68, 8'h64, 8'h00, 8'h00, 8'h00, 8'h06,
        8'h00, 8'h01, 8'h00, 8'h01, 8'h00, 8'h64,
        8'h4D, 8'h54, 8'h72, 8'h6B, 8'h00, 8'h00, 8'h00, 8'h00,
        8'h00, 8'hFF, 8'h51, 8'h03, 8'h07, 8'hA1, 8'h20
    };

    typedef struct packed {
        logic [7:0]  data;
        logic        last;
        logic [31:0] tlen;
    } midi_byte_t;

    // Rows with typed = 1 carry their expected bytes, first byte in the top bits.
    typedef struct packed {
        logic [1:0]  mode;
        logic        rest;
        logic [6:0]  note;
        logic [27:0] dur;
        logic        typed;
        logic [3:0]  cnt;
        logic [63:0] bytes;
        logic [31:0] tlen;
    } stim_row_t;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_tvalid = 1'b0;
    logic        o_s_tready;
    logic [39:0] i_s_tdata = '0;   // note [6:0], duration [34:7], zero [39:35]
    logic [2:0]  i_s_tuser = '0;   // mode [1:0], is_silence [2]
    logic        o_m_tvalid;
    logic        i_m_tready = 1'b0;
    logic [39:0] o_m_tdata;        // out_byte [7:0], track_length [39:8]
    logic        o_m_tlast;
    logic        i_cfg_valid = 1'b0;
    logic        o_cfg_ready;
    logic [7:0]  i_cfg_index = '0;
    logic [6:0]  i_cfg_data = '0;

    tone_events_to_midi_track u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Predictor state.
    logic [6:0]  cfg_instr = 7'd16;
    logic [6:0]  cfg_vel = 7'd64;
    logic [27:0] delta_acc = '0;
    logic [31:0] track_bytes = '0;
    logic [7:0]  run_bytes [0:31];
    int          run_len;
    logic [31:0] run_tlen;
    midi_byte_t  midi_bytes_q [$];

    int n_sent = 0, n_starts = 0, n_notes = 0, n_rests = 0, n_ends = 0, n_ignored = 0;
    int n_checked = 0, n_cfg = 0, err_cnt = 0;
    int quiet = 0, rx_hold = 0;
    bit tx_steady = 1'b0, rx_steady = 1'b0;
    midi_byte_t want_b;
    stim_row_t  dir_tab [0:DIR_ROWS-1];

    // Mostly short gaps, now and then a long one.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    // Spread values over every VLQ length, with the extremes often.
    function automatic logic [27:0] rand_ticks();
        int r;
        int bits;
        r = $urandom_range(0, 9);
        bits = $urandom_range(1, 28);
        if (r == 0) return 28'd0;
        if (r == 1) return TICKS_MAX;
        return 28'($urandom) & (TICKS_MAX >> (28 - bits));
    endfunction

    task automatic put_byte(input logic [7:0] b);
        run_bytes[run_len] = b;
        run_len++;
    endtask

    task automatic put_vlq(input logic [27:0] v);
        int ng;
        int g;
        ng = 1;
        if (v >= 28'h20_0000) ng = 4;
        else if (v >= 28'h4000) ng = 3;
        else if (v >= 28'h80) ng = 2;
        for (g = ng - 1; g >= 0; g--) begin
            put_byte({g != 0, 7'(v >> (7 * g))});
        end
    endtask

    // Works out the bytes one accepted item produces and advances the state.
    task automatic midi_encode(input logic [1:0] mode, input logic rest,
                               input logic [6:0] note, input logic [27:0] dur);
        logic [28:0] sum;
        int i;
        run_len = 0;
        run_tlen = '0;
        case (mode)
            MODE_START: begin
                for (i = 0; i < 29; i++) begin
                    put_byte(SMF_HEAD[(28 - i) * 8 +: 8]);
                end
                put_byte(8'h00);
                put_byte(8'hC0);
                put_byte({1'b0, cfg_instr});
                delta_acc = '0;
                track_bytes = 32'd32;
                n_starts++;
            end
            MODE_TONE: begin
                if (rest) begin
                    sum = {1'b0, delta_acc} + {1'b0, dur};
                    delta_acc = (sum > {1'b0, TICKS_MAX}) ? TICKS_MAX : sum[27:0];
                    n_rests++;
                end else begin
                    put_vlq(delta_acc);
                    put_byte(8'h90);
                    put_byte({1'b0, note});
                    put_byte({1'b0, cfg_vel});
                    put_vlq(dur);
                    put_byte(8'h80);
                    put_byte({1'b0, note});
                    put_byte({1'b0, cfg_vel});
                    delta_acc = '0;
                    track_bytes += 32'(run_len);
                    n_notes++;
                end
            end
            MODE_END: begin
                put_byte(8'h00);
                put_byte(8'hFF);
                put_byte(8'h2F);
                put_byte(8'h00);
                track_bytes += 32'd4;
                run_tlen = track_bytes - CHUNK_OFFSET;
                n_ends++;
            end
            default: n_ignored++;
        endcase
        if (mode != MODE_UNUSED) n_sent++;
    endtask

    task automatic queue_run();
        midi_byte_t m;
        int i;
        for (i = 0; i < run_len; i++) begin
            m.data = run_bytes[i];
            m.last = (i == run_len - 1);
            m.tlen = (i == run_len - 1) ? run_tlen : 32'd0;
            midi_bytes_q.push_back(m);
        end
    endtask

    // Offers one item and returns at the edge where it is taken, then predicts it.
    task automatic drive_item(input logic [1:0] mode, input logic rest,
                              input logic [6:0] note, input logic [27:0] dur);
        int gap;
        gap = tx_steady ? 0 : idle_len();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {5'd0, dur, note};
        i_s_tuser  <= {rest, mode};
        do @(posedge i_clk); while (!o_s_tready);
        midi_encode(mode, rest, note, dur);
    endtask

    task automatic drive_random(input logic [1:0] mode);
        drive_item(mode, 1'($urandom), 7'($urandom), rand_ticks());
        queue_run();
    endtask

    // Holds the input back until every byte is out and the block has gone quiet.
    task automatic settle();
        i_s_tvalid <= 1'b0;
        while (midi_bytes_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Leaves the valid high; the caller lowers it after the last write.
    task automatic write_reg(input logic [7:0] idx, input logic [6:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            REG_INSTRUMENT: cfg_instr = val;
            REG_VELOCITY:   cfg_vel = val;
            default: ;
        endcase
        n_cfg++;
    endtask

    task automatic mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
        err_cnt++;
        if (err_cnt <= 10) begin
            $display("%0t: %s mismatch, expected %h, got %h", $realtime, what, want, got);
        end
    endtask

    // Output side: check every byte taken, and stall at random.
    always @(posedge i_clk) begin
        if (o_m_tvalid && i_m_tready) begin
            if (midi_bytes_q.size() == 0) begin
                mismatch("unexpected byte", 32'd0, {24'd0, o_m_tdata[7:0]});
            end else begin
                want_b = midi_bytes_q.pop_front();
                n_checked++;
                if (o_m_tdata[7:0] !== want_b.data)
                    mismatch("out_byte", {24'd0, want_b.data}, {24'd0, o_m_tdata[7:0]});
                if (o_m_tlast !== want_b.last)
                    mismatch("last_of_run", {31'd0, want_b.last}, {31'd0, o_m_tlast});
                if (o_m_tdata[39:8] !== want_b.tlen)
                    mismatch("track_length", want_b.tlen, o_m_tdata[39:8]);
            end
        end
        if ($urandom_range(0, 299) == 0) rx_steady = !rx_steady;
        if (rx_hold != 0) begin
            i_m_tready <= 1'b0;
            rx_hold = rx_hold - 1;
        end else begin
            i_m_tready <= 1'b1;
            if (!rx_steady) rx_hold = idle_len();
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            quiet = 0;
        end else begin
            quiet++;
        end
        if (quiet >= QUIET_LIMIT) begin
            $display("tb NOT OK");
            $finish;
        end
    end

    initial begin : stimulus
        int i, j, ph, target, k, r;
        stim_row_t row;

        // mode, rest, note, duration, typed, count, bytes, track length
        dir_tab[0]  = '{MODE_END,    1'b0, 7'd0,   28'd0, 1'b1, 4'd4,
                        64'h00FF_2F00_0000_0000, 32'hFFFF_FFEE};
        dir_tab[1]  = '{MODE_TONE,   1'b0, 7'd0,   28'd0, 1'b1, 4'd8,
                        64'h0090_0040_0080_0040, 32'd0};
        dir_tab[2]  = '{MODE_UNUSED, 1'b1, 7'd127, TICKS_MAX, 1'b1, 4'd0, 64'd0, 32'd0};
        dir_tab[3]  = '{MODE_START,  1'b0, 7'd0,   28'd0, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[4]  = '{MODE_END,    1'b1, 7'd127, TICKS_MAX, 1'b1, 4'd4,
                        64'h00FF_2F00_0000_0000, 32'd14};
        dir_tab[5]  = '{MODE_TONE,   1'b0, 7'd127, 28'd0, 1'b1, 4'd8,
                        64'h0090_7F40_0080_7F40, 32'd0};
        dir_tab[6]  = '{MODE_TONE,   1'b1, 7'd0,   TICKS_MAX, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[7]  = '{MODE_TONE,   1'b1, 7'd0,   28'd1, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[8]  = '{MODE_TONE,   1'b0, 7'd127, TICKS_MAX, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[9]  = '{MODE_TONE,   1'b1, 7'd0,   28'd127, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[10] = '{MODE_TONE,   1'b0, 7'd60,  28'd128, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[11] = '{MODE_TONE,   1'b1, 7'd0,   28'd128, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[12] = '{MODE_TONE,   1'b0, 7'd1,   28'd127, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[13] = '{MODE_TONE,   1'b1, 7'd0,   28'd16383, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[14] = '{MODE_TONE,   1'b0, 7'd2,   28'd16384, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[15] = '{MODE_TONE,   1'b1, 7'd0,   28'd16384, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[16] = '{MODE_TONE,   1'b0, 7'd3,   28'd16383, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[17] = '{MODE_TONE,   1'b1, 7'd0,   28'd2097151, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[18] = '{MODE_TONE,   1'b0, 7'd4,   28'd2097152, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[19] = '{MODE_TONE,   1'b1, 7'd0,   28'd2097152, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[20] = '{MODE_TONE,   1'b0, 7'd5,   28'd2097151, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[21] = '{MODE_TONE,   1'b1, 7'd0,   28'd0, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[22] = '{MODE_TONE,   1'b0, 7'd64,  28'd1, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[23] = '{MODE_END,    1'b0, 7'd0,   28'd0, 1'b0, 4'd0, 64'd0, 32'd0};
        dir_tab[24] = '{MODE_START,  1'b1, 7'd127, TICKS_MAX, 1'b0, 4'd0, 64'd0, 32'd0};

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part, run with the reset values of both registers.
        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            drive_item(row.mode, row.rest, row.note, row.dur);
            if (row.typed) begin
                run_len = row.cnt;
                for (j = 0; j < row.cnt; j++) begin
                    run_bytes[j] = row.bytes[63 - 8 * j -: 8];
                end
                run_tlen = row.tlen;
            end
            queue_run();
        end

        // Random part: one register setting per phase, extremes first.
        for (ph = 0; ph < N_PHASES; ph++) begin
            settle();
            case (ph)
                0: begin
                    write_reg(REG_INSTRUMENT, 7'd0);
                    write_reg(REG_VELOCITY, 7'd0);
                end
                1: begin
                    write_reg(REG_INSTRUMENT, 7'd127);
                    write_reg(REG_VELOCITY, 7'd127);
                end
                2: begin
                    write_reg(REG_VELOCITY, 7'($urandom));
                    write_reg(REG_INSTRUMENT, 7'($urandom));
                end
                3: begin
                    write_reg(REG_INSTRUMENT, 7'd127);
                    write_reg(REG_VELOCITY, 7'd0);
                end
                default: write_reg(REG_VELOCITY, 7'($urandom));
            endcase
            i_cfg_valid <= 1'b0;
            target = DIR_ROWS + (ph + 1) * RAND_ITEMS / N_PHASES;
            while (n_sent < target) begin
                tx_steady = ($urandom_range(0, 3) == 0);
                r = $urandom_range(0, 9);
                if (r < 8) begin
                    // A well-formed track: start, a run of notes and rests, end.
                    drive_random(MODE_START);
                    k = $urandom_range(1, 14);
                    repeat (k) begin
                        drive_item(MODE_TONE, $urandom_range(0, 9) < 3,
                                   7'($urandom), rand_ticks());
                        queue_run();
                    end
                    drive_random(MODE_END);
                end else begin
                    drive_random(2'($urandom));
                end
            end
        end

        i_s_tvalid <= 1'b0;
        while (midi_bytes_q.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        $display("Run covered %0d items: %0d starts, %0d notes, %0d rests, %0d ends, %0d ignored.",
                 n_sent + n_ignored, n_starts, n_notes, n_rests, n_ends, n_ignored);
        $display("%0d bytes checked over %0d register writes; %0d mismatches.",
                 n_checked, n_cfg, err_cnt);
        if (err_cnt == 0) begin
            $display("tb OK");
        end else begin
            $display("tb NOT OK");
        end
        $finish;
    end

endmodule
